/* rtl/bbf_pkg.sv */
package bbf_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned EDGE_W      = 13;
  localparam int unsigned SIZE_W      = 13;
  localparam int unsigned SIZE_CALC_W = 15;
  localparam int unsigned COUNT_W     = 19;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [PIX_W-1:0]  BRIGHT_FLOOR_RST = 8'd165;
  localparam logic [PIX_W-1:0]  SAT_LIMIT_RST    = 8'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_BRIGHT_FLOOR = 4'd2,
    REG_SAT_LIMIT    = 4'd3
  } bbf_reg_e;

  typedef enum logic [1:0] {
    REASON_FOUND       = 2'd0,
    REASON_FEW_BRIGHT  = 2'd1,
    REASON_DEGENERATE  = 2'd2,
    REASON_WHOLE_FRAME = 2'd3
  } bbf_reason_e;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } bbf_pixel_t;

  typedef struct packed {
    logic              plate_found;
    bbf_reason_e       reject_reason;
    logic [EDGE_W-1:0] left_edge;
    logic [EDGE_W-1:0] top_edge;
    logic [EDGE_W-1:0] right_edge;
    logic [EDGE_W-1:0] bottom_edge;
  } bbf_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } bbf_cfg_t;

  // Classification of one pixel, handed from the front end to the back end.
  typedef struct packed {
    logic sampled;
    logic bright;
    logic frame_end;
  } bbf_flags_t;

  // A zero size acts as one; anything above the coordinate range is capped.
  function automatic logic [SIZE_CALC_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                        logic [SIZE_CALC_W-1:0] top);
    logic [SIZE_CALC_W-1:0] ext;
    ext = {{(SIZE_CALC_W-SIZE_W){1'b0}}, v};
    if (v == '0) begin
      return SIZE_CALC_W'(1);
    end else if (ext > top) begin
      return top;
    end
    return ext;
  endfunction

endpackage

/* rtl/bbf_stream_if.sv */
interface bbf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/bbf_queue.sv */
module bbf_queue #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_FULL);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue read while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_FULL)
    else $error("queue count beyond depth");

endmodule

/* rtl/bbf_front.sv */
module bbf_front #(
  parameter int unsigned SAMPLE_STEP = 8,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  bbf_stream_if.sink                           pixel_i,
  input  logic [COORD_BITS-1:0]                width_last_i,
  input  logic [COORD_BITS-1:0]                height_last_i,
  input  logic [bbf_pkg::PIX_W-1:0]            floor_i,
  input  logic [bbf_pkg::PIX_W-1:0]            sat_i,
  input  logic                                 queue_full_i,
  output logic                                 push_o,
  output logic [COORD_BITS-1:0]                col_o,
  output logic [COORD_BITS-1:0]                row_o,
  output bbf_pkg::bbf_flags_t                  flags_o
);

  localparam int unsigned PH_W = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(SAMPLE_STEP - 1);

  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  // Position within the sample step, so no modulo is needed on the counters.
  logic [PH_W-1:0] cph_q, cph_d, rph_q, rph_d;

  logic [bbf_pkg::PIX_W-1:0] hi, lo;
  logic row_end, frame_end, sampled, bright;

  always_comb begin
    hi = pixel_i.data.blue;
    lo = pixel_i.data.blue;
    if (pixel_i.data.green > hi) hi = pixel_i.data.green;
    if (pixel_i.data.red > hi) hi = pixel_i.data.red;
    if (pixel_i.data.green < lo) lo = pixel_i.data.green;
    if (pixel_i.data.red < lo) lo = pixel_i.data.red;
  end

  assign row_end   = (col_q >= width_last_i);
  assign frame_end = row_end && (row_q >= height_last_i);
  assign sampled   = (cph_q == '0) && (rph_q == '0);
  assign bright    = sampled && (hi >= floor_i) && ((hi - lo) <= sat_i);

  assign pixel_i.ready = !queue_full_i;
  assign push_o        = pixel_i.valid && !queue_full_i;
  assign col_o         = col_q;
  assign row_o         = row_q;
  assign flags_o       = '{sampled: sampled, bright: bright, frame_end: frame_end};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cph_d = cph_q;
    rph_d = rph_q;
    if (push_o) begin
      if (frame_end) begin
        col_d = '0;
        row_d = '0;
        cph_d = '0;
        rph_d = '0;
      end else if (row_end) begin
        col_d = '0;
        cph_d = '0;
        row_d = row_q + 1'b1;
        rph_d = (rph_q == PH_LAST) ? '0 : rph_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
        cph_d = (cph_q == PH_LAST) ? '0 : cph_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

endmodule

/* rtl/bbf_back.sv */
module bbf_back #(
  parameter int unsigned SAMPLE_STEP = 8,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    entry_valid_i,
  input  logic [COORD_BITS-1:0]   col_i,
  input  logic [COORD_BITS-1:0]   row_i,
  input  bbf_pkg::bbf_flags_t     flags_i,
  output logic                    pop_o,
  input  logic [COORD_BITS:0]     width_i,
  input  logic [COORD_BITS:0]     height_i,
  bbf_stream_if.source            result_o
);

  localparam int unsigned CW = COORD_BITS + 1;
  localparam int unsigned NW = bbf_pkg::COUNT_W;
  localparam logic [CW-1:0] STEP_EXT = CW'(SAMPLE_STEP);

  // Running box and counts of the frame in progress.
  logic [CW-1:0]         min_c_q, min_c_d, min_r_q, min_r_d;
  logic [COORD_BITS-1:0] max_c_q, max_c_d, max_r_q, max_r_d;
  logic [NW-1:0]         bright_q, bright_d, samp_q, samp_d;

  // Totals of a finished frame waiting for the decision.
  logic                  fin_valid_q;
  logic [CW-1:0]         fin_min_c_q, fin_min_r_q;
  logic [COORD_BITS-1:0] fin_max_c_q, fin_max_r_q;
  logic [NW-1:0]         fin_bright_q, fin_samp_q;

  logic                  out_valid_q;
  bbf_pkg::bbf_result_t  out_data_q, res_d;

  logic fin_ready, out_load, close_frame;

  assign out_load    = fin_valid_q && (!out_valid_q || result_o.ready);
  assign fin_ready   = !fin_valid_q || !out_valid_q || result_o.ready;
  assign pop_o       = entry_valid_i && (!flags_i.frame_end || fin_ready);
  assign close_frame = pop_o && flags_i.frame_end;

  always_comb begin
    min_c_d  = min_c_q;
    min_r_d  = min_r_q;
    max_c_d  = max_c_q;
    max_r_d  = max_r_q;
    bright_d = bright_q;
    samp_d   = samp_q;
    if (flags_i.sampled && samp_q != bbf_pkg::COUNT_MAX) begin
      samp_d = samp_q + 1'b1;
    end
    if (flags_i.bright) begin
      if (bright_q != bbf_pkg::COUNT_MAX) bright_d = bright_q + 1'b1;
      if ({1'b0, col_i} < min_c_q) min_c_d = {1'b0, col_i};
      if ({1'b0, row_i} < min_r_q) min_r_d = {1'b0, row_i};
      if (col_i > max_c_q) max_c_d = col_i;
      if (row_i > max_r_q) max_r_d = row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_c_q  <= '1;
      min_r_q  <= '1;
      max_c_q  <= '0;
      max_r_q  <= '0;
      bright_q <= '0;
      samp_q   <= '0;
    end else if (pop_o) begin
      if (flags_i.frame_end) begin
        min_c_q  <= '1;
        min_r_q  <= '1;
        max_c_q  <= '0;
        max_r_q  <= '0;
        bright_q <= '0;
        samp_q   <= '0;
      end else begin
        min_c_q  <= min_c_d;
        min_r_q  <= min_r_d;
        max_c_q  <= max_c_d;
        max_r_q  <= max_r_d;
        bright_q <= bright_d;
        samp_q   <= samp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_frame) begin
      fin_min_c_q  <= min_c_d;
      fin_min_r_q  <= min_r_d;
      fin_max_c_q  <= max_c_d;
      fin_max_r_q  <= max_r_d;
      fin_bright_q <= bright_d;
      fin_samp_q   <= samp_d;
    end
    if (out_load) begin
      out_data_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (close_frame) begin
        fin_valid_q <= 1'b1;
      end else if (out_load) begin
        fin_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Decision on the finished frame.
  logic          few, degen, whole;
  logic [CW-1:0] reach_c, reach_r, right, bottom;

  always_comb begin
    reach_c = {1'b0, fin_max_c_q} + STEP_EXT;
    reach_r = {1'b0, fin_max_r_q} + STEP_EXT;
    right   = (reach_c > width_i) ? width_i : reach_c;
    bottom  = (reach_r > height_i) ? height_i : reach_r;
    few     = {fin_bright_q, 2'b00} < {2'b00, fin_samp_q};
    degen   = ({1'b0, fin_max_c_q} <= fin_min_c_q) || ({1'b0, fin_max_r_q} <= fin_min_r_q);
    whole   = (fin_min_c_q < STEP_EXT) && (fin_min_r_q < STEP_EXT) &&
              (reach_c >= width_i) && (reach_r >= height_i);
    res_d   = '0;
    priority if (few) begin
      res_d.reject_reason = bbf_pkg::REASON_FEW_BRIGHT;
    end else if (degen) begin
      res_d.reject_reason = bbf_pkg::REASON_DEGENERATE;
    end else if (whole) begin
      res_d.reject_reason = bbf_pkg::REASON_WHOLE_FRAME;
    end else begin
      res_d.plate_found   = 1'b1;
      res_d.reject_reason = bbf_pkg::REASON_FOUND;
      res_d.left_edge     = bbf_pkg::EDGE_W'(fin_min_c_q);
      res_d.top_edge      = bbf_pkg::EDGE_W'(fin_min_r_q);
      res_d.right_edge    = bbf_pkg::EDGE_W'(right);
      res_d.bottom_edge   = bbf_pkg::EDGE_W'(bottom);
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      (result_o.data.plate_found == (result_o.data.reject_reason == bbf_pkg::REASON_FOUND)))
    else $error("found flag disagrees with reject reason");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && !out_load |=> fin_valid_q && $stable(fin_samp_q) && $stable(fin_bright_q))
    else $error("pending frame totals lost or changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |=> result_o.valid && $stable(result_o.data))
    else $error("result word dropped or changed while waiting");

endmodule

/* rtl/bright_region_bbox_finder_core.sv */
// Channel    Direction  Payload                                      Word
// pixel_i    in         blue, green, red                             one pixel, raster order
// cfg_i      in         index, value                                 one register write
// result_o   out        plate_found, reject_reason, four box edges   one result per frame
//
// One pixel is accepted every cycle while the four-entry queue between the
// pixel classifier and the box accumulator has room.
// Once the last pixel leaves the queue, frame totals and then the result are registered.
// Reset clears counters, box, queue and outputs and loads the default sizes
// and thresholds. A stalled result holds the decision stage, and pixels keep
// flowing until the queue fills behind the last pixel of the frame after that.
module bright_region_bbox_finder_core #(
  parameter int unsigned SAMPLE_STEP = 8,
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bbf_stream_if.sink    pixel_i,
  bbf_stream_if.sink    cfg_i,
  bbf_stream_if.source  result_o
);

  localparam int unsigned CW = COORD_BITS + 1;
  localparam int unsigned FLAGS_W = $bits(bbf_pkg::bbf_flags_t);
  localparam int unsigned ENTRY_W = FLAGS_W + 2 * COORD_BITS;
  localparam logic [bbf_pkg::SIZE_CALC_W-1:0] SIZE_TOP =
    bbf_pkg::SIZE_CALC_W'(2 ** COORD_BITS);

  logic [CW-1:0]                width_q, height_q;
  logic [bbf_pkg::PIX_W-1:0]    floor_q, sat_q;
  logic [COORD_BITS-1:0]        width_last, height_last;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(bbf_pkg::clamp_size(bbf_pkg::FRAME_WIDTH_RST, SIZE_TOP));
      height_q <= CW'(bbf_pkg::clamp_size(bbf_pkg::FRAME_HEIGHT_RST, SIZE_TOP));
      floor_q  <= bbf_pkg::BRIGHT_FLOOR_RST;
      sat_q    <= bbf_pkg::SAT_LIMIT_RST;
    end else if (cfg_i.valid) begin
      unique case (bbf_pkg::bbf_reg_e'(cfg_i.data.index))
        bbf_pkg::REG_FRAME_WIDTH: begin
          width_q <= CW'(bbf_pkg::clamp_size(cfg_i.data.value, SIZE_TOP));
        end
        bbf_pkg::REG_FRAME_HEIGHT: begin
          height_q <= CW'(bbf_pkg::clamp_size(cfg_i.data.value, SIZE_TOP));
        end
        bbf_pkg::REG_BRIGHT_FLOOR: begin
          floor_q <= cfg_i.data.value[bbf_pkg::PIX_W-1:0];
        end
        bbf_pkg::REG_SAT_LIMIT: begin
          sat_q <= cfg_i.data.value[bbf_pkg::PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Sizes are at least one after clamping, so the last index never wraps.
  assign width_last  = COORD_BITS'(width_q - 1'b1);
  assign height_last = COORD_BITS'(height_q - 1'b1);

  logic                  push, pop, q_full, q_empty;
  logic [COORD_BITS-1:0] fr_col, fr_row, bk_col, bk_row;
  bbf_pkg::bbf_flags_t   fr_flags, bk_flags;
  logic [ENTRY_W-1:0]    q_in, q_out;

  bbf_front #(
    .SAMPLE_STEP (SAMPLE_STEP),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_i       (pixel_i),
    .width_last_i  (width_last),
    .height_last_i (height_last),
    .floor_i       (floor_q),
    .sat_i         (sat_q),
    .queue_full_i  (q_full),
    .push_o        (push),
    .col_o         (fr_col),
    .row_o         (fr_row),
    .flags_o       (fr_flags)
  );

  assign q_in = {fr_flags, fr_col, fr_row};

  bbf_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  assign {bk_flags, bk_col, bk_row} = q_out;

  bbf_back #(
    .SAMPLE_STEP (SAMPLE_STEP),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (!q_empty),
    .col_i         (bk_col),
    .row_i         (bk_row),
    .flags_i       (bk_flags),
    .pop_o         (pop),
    .width_i       (width_q),
    .height_i      (height_q),
    .result_o      (result_o)
  );

endmodule

/* sim/bright_region_bbox_finder_core_tb.sv */
module bright_region_bbox_finder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEP        = 8;
  localparam int unsigned SIZE_CAP    = 4096;
  localparam int unsigned COUNT_SAT   = 32'h7FFFF;
  localparam int unsigned MIN_CLEAR   = 32'h1FFF;
  localparam int unsigned DRAIN       = 16;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef enum bit {STEP_PIXEL, STEP_WRITE} step_kind_e;

  typedef struct {
    step_kind_e           kind;
    bbf_pkg::bbf_pixel_t  pix;
    bbf_pkg::bbf_reg_e    idx;
    int unsigned          val;
    bit                   typed;
    bbf_pkg::bbf_result_t want;
  } step_t;

  logic clk_i;
  logic rst_ni;

  bbf_stream_if #(.T(bbf_pkg::bbf_pixel_t))  pix_if ();
  bbf_stream_if #(.T(bbf_pkg::bbf_cfg_t))    cfg_if ();
  bbf_stream_if #(.T(bbf_pkg::bbf_result_t)) res_if ();

  bright_region_bbox_finder_core #(
    .SAMPLE_STEP(STEP),
    .COORD_BITS (12)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pix_if),
    .cfg_i   (cfg_if),
    .result_o(res_if)
  );

  // Shadow of the frame geometry, thresholds and accumulated box.
  int unsigned cfg_width, cfg_height, cfg_floor, cfg_sat;
  int unsigned col_cnt, row_cnt, min_col, min_row, max_col, max_row;
  int unsigned bright_cnt, sample_cnt;

  bbf_pkg::bbf_result_t pending_boxes[$];
  step_t                directed_steps[$];

  int unsigned mismatches    = 0;
  int unsigned boxes_issued  = 0;
  int unsigned rand_pixels   = 0;
  int unsigned pix_gap_max   = 8;
  int unsigned res_stall_max = 8;
  bit          hold_results  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned clipped_size(int unsigned v);
    if (v == 0) return 1;
    if (v > SIZE_CAP) return SIZE_CAP;
    return v;
  endfunction

  function automatic void clear_frame();
    col_cnt    = 0;
    row_cnt    = 0;
    min_col    = MIN_CLEAR;
    min_row    = MIN_CLEAR;
    max_col    = 0;
    max_row    = 0;
    bright_cnt = 0;
    sample_cnt = 0;
  endfunction

  function automatic void reset_model();
    cfg_width  = 640;
    cfg_height = 480;
    cfg_floor  = 165;
    cfg_sat    = 60;
    clear_frame();
  endfunction

  function automatic void apply_reg(bbf_pkg::bbf_reg_e idx, int unsigned v);
    case (idx)
      bbf_pkg::REG_FRAME_WIDTH:  cfg_width  = v & 32'h1FFF;
      bbf_pkg::REG_FRAME_HEIGHT: cfg_height = v & 32'h1FFF;
      bbf_pkg::REG_BRIGHT_FLOOR: cfg_floor  = v & 32'hFF;
      bbf_pkg::REG_SAT_LIMIT:    cfg_sat    = v & 32'hFF;
      default: ;
    endcase
  endfunction

  // Advances the raster position by one pixel; on the last pixel of a frame
  // it decides the box and starts over.
  function automatic void track_pixel(input bbf_pkg::bbf_pixel_t p, output bit done,
                                      output bbf_pkg::bbf_result_t box);
    int unsigned w, h, hi, lo, re, be;
    bit row_end, frame_end;
    bbf_pkg::bbf_reason_e why;
    w = clipped_size(cfg_width);
    h = clipped_size(cfg_height);
    hi = p.blue;
    lo = p.blue;
    if (p.green > hi) hi = p.green;
    if (p.red > hi) hi = p.red;
    if (p.green < lo) lo = p.green;
    if (p.red < lo) lo = p.red;
    row_end = col_cnt >= w - 1;
    frame_end = row_end && row_cnt >= h - 1;
    done = 1'b0;
    box = '0;
    if (col_cnt % STEP == 0 && row_cnt % STEP == 0) begin
      if (sample_cnt < COUNT_SAT) sample_cnt++;
      if (hi >= cfg_floor && hi - lo <= cfg_sat) begin
        if (bright_cnt < COUNT_SAT) bright_cnt++;
        if (col_cnt < min_col) min_col = col_cnt;
        if (row_cnt < min_row) min_row = row_cnt;
        if (col_cnt > max_col) max_col = col_cnt;
        if (row_cnt > max_row) max_row = row_cnt;
      end
    end
    if (frame_end) begin
      if (bright_cnt * 4 < sample_cnt) begin
        why = bbf_pkg::REASON_FEW_BRIGHT;
      end else if (max_col <= min_col || max_row <= min_row) begin
        why = bbf_pkg::REASON_DEGENERATE;
      end else if (min_col < STEP && min_row < STEP &&
                   max_col + STEP >= w && max_row + STEP >= h) begin
        why = bbf_pkg::REASON_WHOLE_FRAME;
      end else begin
        why = bbf_pkg::REASON_FOUND;
      end
      box.reject_reason = why;
      if (why == bbf_pkg::REASON_FOUND) begin
        re = max_col + STEP;
        be = max_row + STEP;
        if (re > w) re = w;
        if (be > h) be = h;
        box.plate_found = 1'b1;
        box.left_edge   = 13'(min_col);
        box.top_edge    = 13'(min_row);
        box.right_edge  = 13'(re);
        box.bottom_edge = 13'(be);
      end
      done = 1'b1;
      clear_frame();
    end else if (row_end) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 32'hFFF;
    end else begin
      col_cnt = (col_cnt + 1) & 32'hFFF;
    end
  endfunction

  function automatic int unsigned draw_wait(int unsigned cap);
    if (cap == 0 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, cap);
  endfunction

  function automatic int unsigned pick_level();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // A lit pixel passes the current thresholds; any other is plain noise.
  function automatic bbf_pkg::bbf_pixel_t make_pixel(bit lit);
    bbf_pkg::bbf_pixel_t p;
    int unsigned hi, lo, spread;
    if (lit) begin
      hi = $urandom_range(cfg_floor, 255);
      spread = $urandom_range(0, (cfg_sat < hi) ? cfg_sat : hi);
      lo = hi - spread;
      p.blue  = 8'($urandom_range(lo, hi));
      p.green = 8'($urandom_range(lo, hi));
      p.red   = 8'($urandom_range(lo, hi));
      case ($urandom_range(0, 2))
        0: p.blue = 8'(hi);
        1: p.green = 8'(hi);
        default: p.red = 8'(hi);
      endcase
    end else begin
      p.blue  = 8'($urandom_range(0, 255));
      p.green = 8'($urandom_range(0, 255));
      p.red   = 8'($urandom_range(0, 255));
    end
    return p;
  endfunction

  function automatic void add_pixel(int unsigned b, int unsigned g, int unsigned r,
                                    bit typed = 1'b0,
                                    bbf_pkg::bbf_reason_e why = bbf_pkg::REASON_FOUND);
    step_t s;
    s.kind      = STEP_PIXEL;
    s.pix.blue  = 8'(b);
    s.pix.green = 8'(g);
    s.pix.red   = 8'(r);
    s.idx       = bbf_pkg::REG_FRAME_WIDTH;
    s.val       = 0;
    s.typed     = typed;
    s.want      = '0;
    s.want.reject_reason = why;
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic void add_write(bbf_pkg::bbf_reg_e idx, int unsigned v);
    step_t s;
    s.kind  = STEP_WRITE;
    s.pix   = '0;
    s.idx   = idx;
    s.val   = v;
    s.typed = 1'b0;
    s.want  = '0;
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Lowers the pixel valid and waits until the block has nothing left in flight.
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(bbf_pkg::bbf_reg_e idx, int unsigned v);
    settle();
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.value <= 13'(v);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_reg(idx, v);
  endtask

  task automatic send_pixel(input bbf_pkg::bbf_pixel_t p, input bit typed,
                            input bbf_pkg::bbf_result_t want, output bit done);
    int unsigned gap;
    bbf_pkg::bbf_result_t box;
    gap = draw_wait(pix_gap_max);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= p;
    do @(posedge clk_i); while (!pix_if.ready);
    track_pixel(p, done, box);
    if (done) begin
      boxes_issued++;
      pending_boxes.insert(pending_boxes.size(), typed ? want : box);
    end
  endtask

  // Streams whole frames with a random bright rectangle (or noise), then
  // possibly a partial frame that the next setting has to finish.
  task automatic run_phase(int unsigned w_reg, int unsigned h_reg, int unsigned frames);
    int unsigned w, h, c0, c1, r0, r1, extra, mode;
    bit done, lit, repick;
    write_reg(bbf_pkg::REG_FRAME_WIDTH, w_reg);
    write_reg(bbf_pkg::REG_FRAME_HEIGHT, h_reg);
    write_reg(bbf_pkg::REG_BRIGHT_FLOOR, pick_level());
    write_reg(bbf_pkg::REG_SAT_LIMIT, pick_level());
    w = clipped_size(w_reg);
    h = clipped_size(h_reg);
    pix_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
    res_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
    extra = (w * h > 1 && w * h <= 300 && $urandom_range(0, 3) == 0) ?
            $urandom_range(1, w * h - 1) : 0;
    repick = 1'b1;
    mode = 0;
    c0 = 0; c1 = 0; r0 = 0; r1 = 0;
    while (frames != 0 || extra != 0) begin
      if (repick) begin
        mode = $urandom_range(0, 3);
        if (mode == 0) begin
          c0 = 0; c1 = w - 1; r0 = 0; r1 = h - 1;
        end else begin
          c0 = $urandom_range(0, w - 1);
          c1 = $urandom_range(c0, w - 1);
          r0 = $urandom_range(0, h - 1);
          r1 = $urandom_range(r0, h - 1);
        end
        repick = 1'b0;
      end
      if (mode == 3) begin
        lit = $urandom_range(0, 1);
      end else begin
        lit = col_cnt >= c0 && col_cnt <= c1 && row_cnt >= r0 && row_cnt <= r1 &&
              $urandom_range(0, 9) != 0;
      end
      send_pixel(make_pixel(lit), 1'b0, '0, done);
      rand_pixels++;
      if (frames == 0) begin
        extra--;
      end else if (done) begin
        frames--;
        repick = 1'b1;
      end
    end
  endtask

  // Result side: random stalls, one long hold-off on request, and the checks.
  initial begin
    int unsigned stall;
    bbf_pkg::bbf_result_t got, want;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(res_stall_max);
      if (hold_results) begin
        hold_results = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got = res_if.data;
      if (pending_boxes.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending, reason %0d",
                                  got.reject_reason));
      end else begin
        want = pending_boxes.pop_front();
        compare_field("plate_found", got.plate_found, want.plate_found);
        compare_field("reject_reason", got.reject_reason, want.reject_reason);
        compare_field("left_edge", got.left_edge, want.left_edge);
        compare_field("top_edge", got.top_edge, want.top_edge);
        compare_field("right_edge", got.right_edge, want.right_edge);
        compare_field("bottom_edge", got.bottom_edge, want.bottom_edge);
      end
    end
  end

  initial begin
    bit done;
    int unsigned results_start;
    rst_ni       = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset thresholds, with the pixel sitting exactly on both limits.
    add_pixel(165, 105, 130);
    // Shrinking the frame mid-row: the counter is past the new last column.
    add_write(bbf_pkg::REG_FRAME_WIDTH, 0);
    add_write(bbf_pkg::REG_FRAME_HEIGHT, 1);
    add_pixel(0, 0, 0, 1'b1, bbf_pkg::REASON_DEGENERATE);
    // One-pixel frames: a lone bright sample is a degenerate box, a dark one too few bright.
    add_pixel(0, 0, 0, 1'b1, bbf_pkg::REASON_FEW_BRIGHT);
    add_pixel(255, 255, 255, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_pixel(164, 164, 164, 1'b1, bbf_pkg::REASON_FEW_BRIGHT);
    add_pixel(255, 195, 255, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_pixel(255, 194, 255, 1'b1, bbf_pkg::REASON_FEW_BRIGHT);
    add_pixel(195, 255, 255, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_pixel(255, 255, 195, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_pixel(130, 165, 105, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_pixel(105, 130, 165, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_write(bbf_pkg::REG_BRIGHT_FLOOR, 0);
    add_write(bbf_pkg::REG_SAT_LIMIT, 255);
    add_pixel(0, 0, 0, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_pixel(255, 0, 0, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_write(bbf_pkg::REG_BRIGHT_FLOOR, 255);
    add_write(bbf_pkg::REG_SAT_LIMIT, 0);
    add_pixel(255, 255, 255, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_pixel(254, 254, 254, 1'b1, bbf_pkg::REASON_FEW_BRIGHT);
    add_pixel(255, 255, 254, 1'b1, bbf_pkg::REASON_FEW_BRIGHT);
    // A zero height acts as one row; column one is never sampled.
    add_write(bbf_pkg::REG_FRAME_WIDTH, 2);
    add_write(bbf_pkg::REG_FRAME_HEIGHT, 0);
    add_pixel(255, 255, 255);
    add_pixel(0, 0, 0, 1'b1, bbf_pkg::REASON_DEGENERATE);
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    // A width above the range is capped, so the row runs on until it shrinks.
    add_write(bbf_pkg::REG_FRAME_WIDTH, 8191);
    add_write(bbf_pkg::REG_FRAME_HEIGHT, 1);
    add_pixel(255, 255, 255);
    add_pixel(0, 0, 0);
    add_pixel(0, 0, 0);
    add_write(bbf_pkg::REG_FRAME_WIDTH, 1);
    add_pixel(0, 0, 0, 1'b1, bbf_pkg::REASON_DEGENERATE);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        write_reg(directed_steps[i].idx, directed_steps[i].val);
      end else begin
        send_pixel(directed_steps[i].pix, directed_steps[i].typed,
                   directed_steps[i].want, done);
      end
    end

    // Hold the result word back while one-pixel frames keep coming, so the
    // internal queue fills and the pixel input stalls.
    hold_results = 1'b1;
    run_phase(1, 1, 40);

    rand_pixels = 0;
    results_start = boxes_issued;
    while (rand_pixels < 1000 || boxes_issued - results_start < 40) begin
      if ($urandom_range(0, 9) < 6) begin
        run_phase($urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(1, 6));
      end else begin
        run_phase($urandom_range(9, 20), $urandom_range(9, 12), $urandom_range(1, 3));
      end
    end

    settle();
    if (mismatches == 0 && pending_boxes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bbf_pkg.sv
rtl/bbf_stream_if.sv
rtl/bbf_queue.sv
rtl/bbf_front.sv
rtl/bbf_back.sv
rtl/bright_region_bbox_finder_core.sv
sim/bright_region_bbox_finder_core_tb.sv
